[rtl/eus_pkg.sv]
// eus_pkg: shared types and decode functions for the extended utf-8 stream decoder
// no dependencies
`default_nettype none

package eus_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 32;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned CONT_W = 6;

  localparam logic [LEN_W-1:0] LEN_BAD    = 3'd0;
  localparam logic [LEN_W-1:0] LEN_SINGLE = 3'd1;

  localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3f;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             bad_head;
    logic [LEN_W-1:0] seq_length;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_t;

  // sequence length from leading ones of a head byte, zero for an invalid head
  function automatic logic [LEN_W-1:0] head_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    unique case (b) inside
      [8'h00:8'h7f]: len = 3'd1;
      [8'h80:8'hbf]: len = LEN_BAD;
      [8'hc0:8'hdf]: len = 3'd2;
      [8'he0:8'hef]: len = 3'd3;
      [8'hf0:8'hf7]: len = 3'd4;
      [8'hf8:8'hfb]: len = 3'd5;
      [8'hfc:8'hfd]: len = 3'd6;
      8'hfe:         len = 3'd7;
      default:       len = LEN_BAD;
    endcase
    return len;
  endfunction

  // payload bits kept from a head byte of the given length
  function automatic logic [BYTE_W-1:0] head_mask(input logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] m;
    unique case (len)
      3'd1:    m = 8'h7f;
      3'd2:    m = 8'h1f;
      3'd3:    m = 8'h0f;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/eus_in_stage.sv]
// eus_in_stage: input register holding one byte item
// depends on eus_pkg
`default_nettype none

module eus_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [eus_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       advance,
  output logic                            held_valid,
  output logic [eus_pkg::BYTE_W-1:0]      held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= data_byte;
    end
  end

endmodule

`default_nettype wire

[rtl/eus_step.sv]
// eus_step: sequence state registers and the per-byte decode step
// depends on eus_pkg
`default_nettype none

module eus_step (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic [eus_pkg::BYTE_W-1:0] held_byte,
  output eus_pkg::step_t                  step
);

  logic [eus_pkg::CP_W-1:0]  accumulator;
  logic [eus_pkg::CP_W-1:0]  accumulator_next;
  logic [eus_pkg::LEN_W-1:0] expected_length;
  logic [eus_pkg::LEN_W-1:0] expected_length_next;
  logic [eus_pkg::LEN_W-1:0] bytes_taken;
  logic [eus_pkg::LEN_W-1:0] bytes_taken_next;

  logic                      idle;
  logic [eus_pkg::LEN_W-1:0] len;
  logic [eus_pkg::CP_W-1:0]  cont_acc;
  logic [eus_pkg::LEN_W-1:0] taken_inc;

  assign idle      = (bytes_taken == '0) || (bytes_taken >= expected_length);
  assign len       = eus_pkg::head_length(held_byte);
  assign cont_acc  = {accumulator[eus_pkg::CP_W-eus_pkg::CONT_W-1:0],
                      held_byte[eus_pkg::CONT_W-1:0]};
  assign taken_inc = bytes_taken + 3'd1;

  always_comb begin
    accumulator_next     = accumulator;
    expected_length_next = expected_length;
    bytes_taken_next     = bytes_taken;
    step.emit            = 1'b0;
    step.res.code_point  = {24'd0, held_byte};
    step.res.bad_head    = 1'b0;
    step.res.seq_length  = eus_pkg::LEN_SINGLE;
    if (idle) begin
      bytes_taken_next = '0;
      if (len == eus_pkg::LEN_BAD) begin
        accumulator_next     = '0;
        expected_length_next = '0;
        step.emit            = 1'b1;
        step.res.bad_head    = 1'b1;
      end else if (len == eus_pkg::LEN_SINGLE) begin
        accumulator_next     = '0;
        expected_length_next = '0;
        step.emit            = 1'b1;
      end else begin
        accumulator_next     = {24'd0, held_byte & eus_pkg::head_mask(len)};
        expected_length_next = len;
        bytes_taken_next     = 3'd1;
      end
    end else if (taken_inc >= expected_length) begin
      accumulator_next     = '0;
      expected_length_next = '0;
      bytes_taken_next     = '0;
      step.emit            = 1'b1;
      step.res.code_point  = cont_acc;
      step.res.seq_length  = expected_length;
    end else begin
      accumulator_next = cont_acc;
      bytes_taken_next = taken_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      expected_length <= '0;
      bytes_taken     <= '0;
    end else if (advance) begin
      accumulator     <= accumulator_next;
      expected_length <= expected_length_next;
      bytes_taken     <= bytes_taken_next;
    end
  end

endmodule

`default_nettype wire

[rtl/eus_out_stage.sv]
// eus_out_stage: result register toward the output channel
// depends on eus_pkg
`default_nettype none

module eus_out_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        held_valid,
  input  wire eus_pkg::step_t              step,
  output logic                             advance,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [eus_pkg::CP_W-1:0]         code_point,
  output logic                             bad_head,
  output logic [eus_pkg::LEN_W-1:0]        seq_length
);

  eus_pkg::result_t res;

  assign advance    = held_valid && (!out_valid || out_ready);
  assign code_point = res.code_point;
  assign bad_head   = res.bad_head;
  assign seq_length = res.seq_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      res <= step.res;
    end
  end

endmodule

`default_nettype wire

[rtl/extended_utf8_stream_decoder.sv]
// extended_utf8_stream_decoder: top level of the 1 to 7 byte extended utf-8 decoder
// depends on eus_pkg, eus_in_stage, eus_step, eus_out_stage
`default_nettype none

// Takes one byte item per cycle while results are taken and emits one result
// item when a sequence completes: a single byte 0x00-0x7f or an invalid head
// (0x80-0xbf, 0xff) gives a result at once, a head of length n gives one after
// its n-th byte. A byte passes an input register, then the decode step updates
// the sequence state and loads the result register. Throughput is one byte
// per cycle while results are taken, set by the single state update in the
// decode step; while the result register is full and not taken, one more byte
// is held in the input register before in_ready drops.
module extended_utf8_stream_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [eus_pkg::BYTE_W-1:0] data_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [eus_pkg::CP_W-1:0]        code_point,
  output logic                            bad_head,
  output logic [eus_pkg::LEN_W-1:0]       seq_length
);

  logic                       advance;
  logic                       held_valid;
  logic [eus_pkg::BYTE_W-1:0] held_byte;
  eus_pkg::step_t             step;

  eus_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  eus_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .held_byte (held_byte),
    .step      (step)
  );

  eus_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .step       (step),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .bad_head   (bad_head),
    .seq_length (seq_length)
  );

endmodule

`default_nettype wire

[rtl/eus_checker.sv]
// eus_checker: port-level assertions for the extended utf-8 stream decoder
// depends on eus_pkg; bound to extended_utf8_stream_decoder
`default_nettype none

module eus_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [eus_pkg::BYTE_W-1:0] data_byte,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [eus_pkg::CP_W-1:0]   code_point,
  input wire logic                       bad_head,
  input wire logic [eus_pkg::LEN_W-1:0]  seq_length
);

  // a stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(bad_head)
      && $stable(seq_length))
    else $error("result item changed while stalled");

  // input stalls only behind a stalled result, and the waiting item holds
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready
      ##1 in_valid && $stable(data_byte))
    else $error("input stalled without a stalled result");

  // an error item carries the offending byte with length one
  a_bad_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_head |-> seq_length == eus_pkg::LEN_SINGLE
      && code_point[31:8] == 24'd0
      && (code_point[7:6] == 2'b10 || code_point[7:0] == 8'hff))
    else $error("malformed error item");

  // a single-byte result is plain ascii
  a_single_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_head && seq_length == eus_pkg::LEN_SINGLE
      |-> code_point[31:7] == 25'd0)
    else $error("single-byte result out of range");

  // no result item right after reset, and never a zero length
  a_len_nonzero: assert property (@(posedge clk)
    (rst |=> !out_valid) and (out_valid |-> seq_length != eus_pkg::LEN_BAD))
    else $error("bad result valid or zero length");

endmodule

bind extended_utf8_stream_decoder eus_checker u_eus_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .data_byte  (data_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .code_point (code_point),
  .bad_head   (bad_head),
  .seq_length (seq_length)
);

`default_nettype wire
